// ===== rtl/tpd_pkg.sv =====
package tpd_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_TYPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_TYPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_TYPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_END   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_END  = 3'd5;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_SINGLE = 3'd3;
  localparam logic [2:0] PH_CTRL   = 3'd4;
  localparam logic [2:0] PH_MULTI  = 3'd5;
  localparam logic [2:0] PH_DROP   = 3'd6;

  localparam logic [2:0] KIND_PACKET_DATA  = 3'd0;
  localparam logic [2:0] KIND_SEGMENT_DATA = 3'd1;
  localparam logic [2:0] KIND_CONTROL      = 3'd2;
  localparam logic [2:0] KIND_PACKET_END   = 3'd3;
  localparam logic [2:0] KIND_SEGMENT_END  = 3'd4;
  localparam logic [2:0] KIND_TYPE_ERROR   = 3'd5;

  localparam logic [3:0]  ADDR_BYTES   = 4'd12;
  localparam logic [15:0] LEN_OVERHEAD = 16'd14;

  typedef struct packed {
    logic [7:0] single_type_code;
    logic [7:0] error_type_code;
    logic [7:0] control_type_code;
    logic [7:0] multi_type_code;
    logic [7:0] packet_end_marker;
    logic [7:0] segment_end_marker;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  out_kind;
    logic [15:0] out_length;
    logic [7:0]  out_frame_number;
  } res_t;

endpackage

// ===== rtl/tunnelled_packet_deframer.sv =====
// channel | signals                                   | role
// input   | in_valid in_ready rx_byte frame_start     | one frame byte per beat
// output  | out_valid out_ready out_byte out_kind     | one result per beat
//         | out_length out_frame_number               |
// config  | cfg_we cfg_index cfg_data                 | register write, no wait
//
// one input beat per cycle while in_ready is high; a result passes through the
// input register, then a two-entry output buffer
// synchronous active-high reset restores register defaults and the idle frame state
// with out_ready low the buffer fills, then in_ready drops with one beat held in the
// input register
module tunnelled_packet_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic [2:0]                    out_kind,
  output logic [15:0]                   out_length,
  output logic [7:0]                    out_frame_number,
  input  logic                          cfg_we,
  input  logic [tpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import tpd_pkg::*;

  cfg_t cfg;
  res_t push_data;
  res_t out_data;
  logic push_valid;
  logic buf_ready;

  tpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .buf_ready   (buf_ready),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  tpd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .buf_ready  (buf_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_byte         = out_data.out_byte;
  assign out_kind         = out_data.out_kind;
  assign out_length       = out_data.out_length;
  assign out_frame_number = out_data.out_frame_number;

endmodule

// ===== rtl/tpd_cfg_regs.sv =====
module tpd_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                cfg_data,
  output tpd_pkg::cfg_t             cfg
);
  import tpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_type_code   <= 8'd80;
      cfg.error_type_code    <= 8'd69;
      cfg.control_type_code  <= 8'd67;
      cfg.multi_type_code    <= 8'd77;
      cfg.packet_end_marker  <= 8'd34;
      cfg.segment_end_marker <= 8'd35;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SINGLE_TYPE:  cfg.single_type_code   <= cfg_data;
        REG_ERROR_TYPE:   cfg.error_type_code    <= cfg_data;
        REG_CONTROL_TYPE: cfg.control_type_code  <= cfg_data;
        REG_MULTI_TYPE:   cfg.multi_type_code    <= cfg_data;
        REG_PACKET_END:   cfg.packet_end_marker  <= cfg_data;
        REG_SEGMENT_END:  cfg.segment_end_marker <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tpd_core.sv =====
module tpd_core (
  input  logic          clk,
  input  logic          rst,
  input  tpd_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  input  logic          frame_start,
  input  logic          buf_ready,
  output logic          push_valid,
  output tpd_pkg::res_t push_data
);
  import tpd_pkg::*;

  // input register
  logic       iv;
  logic [7:0] ib;
  logic       is;

  logic [2:0]  phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [15:0] payload_left, payload_left_next;
  logic [7:0]  length_high_byte, length_high_byte_next;
  logic [15:0] sub_count, sub_count_next;
  logic [15:0] multi_total, multi_total_next;
  logic [7:0]  segment_number, segment_number_next;

  logic        fire;
  logic [15:0] left_dec;
  logic [15:0] sub_inc;
  logic [15:0] len;
  logic [15:0] total_sum;
  logic [2:0]  done_phase;

  assign fire     = iv && buf_ready;
  assign in_ready = !iv || buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ib <= rx_byte;
      is <= frame_start;
    end
  end

  always_comb begin
    left_dec   = (payload_left != 16'd0) ? payload_left - 16'd1 : 16'd0;
    sub_inc    = sub_count + 16'd1;
    len        = {length_high_byte, ib};
    total_sum  = multi_total + sub_inc;
    done_phase = (left_dec == 16'd0) ? PH_DROP : PH_TYPE;

    phase_next            = phase;
    header_count_next     = header_count;
    payload_left_next     = payload_left;
    length_high_byte_next = length_high_byte;
    sub_count_next        = sub_count;
    multi_total_next      = multi_total;
    segment_number_next   = segment_number;
    push_valid            = 1'b0;
    push_data             = '0;

    if (is) begin
      phase_next        = PH_HEADER;
      header_count_next = 4'd1;
      sub_count_next    = 16'd0;
      payload_left_next = 16'd0;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (header_count < ADDR_BYTES) begin
            header_count_next = header_count + 4'd1;
          end else if (header_count == ADDR_BYTES) begin
            length_high_byte_next = ib;
            header_count_next     = ADDR_BYTES + 4'd1;
          end else begin
            payload_left_next = (len >= LEN_OVERHEAD) ? len - LEN_OVERHEAD : 16'd0;
            header_count_next = 4'd0;
            phase_next        = (len > LEN_OVERHEAD) ? PH_TYPE : PH_DROP;
          end
        end
        PH_TYPE: begin
          sub_count_next    = 16'd1;
          payload_left_next = left_dec;
          if (ib == cfg.single_type_code) begin
            phase_next = PH_SINGLE;
          end else if (ib == cfg.error_type_code) begin
            phase_next         = PH_DROP;
            push_valid         = 1'b1;
            push_data.out_kind = KIND_TYPE_ERROR;
          end else if (ib == cfg.control_type_code) begin
            phase_next = PH_CTRL;
          end else if (ib == cfg.multi_type_code) begin
            segment_number_next = segment_number + 8'd1;
            phase_next          = PH_MULTI;
          end else begin
            phase_next         = PH_DROP;
            push_valid         = 1'b1;
            push_data.out_kind = KIND_TYPE_ERROR;
          end
        end
        PH_SINGLE: begin
          sub_count_next       = sub_inc;
          payload_left_next    = left_dec;
          push_valid           = 1'b1;
          push_data.out_length = sub_inc;
          if (ib == cfg.packet_end_marker) begin
            push_data.out_kind = KIND_PACKET_END;
            phase_next         = done_phase;
          end else begin
            push_data.out_byte = ib;
            push_data.out_kind = KIND_PACKET_DATA;
          end
        end
        PH_CTRL: begin
          sub_count_next       = sub_inc;
          payload_left_next    = left_dec;
          push_valid           = 1'b1;
          push_data.out_byte   = ib;
          push_data.out_kind   = KIND_CONTROL;
          push_data.out_length = sub_inc;
          phase_next           = done_phase;
        end
        PH_MULTI: begin
          sub_count_next             = sub_inc;
          payload_left_next          = left_dec;
          push_valid                 = 1'b1;
          push_data.out_frame_number = segment_number;
          if (ib == cfg.segment_end_marker) begin
            multi_total_next     = total_sum;
            push_data.out_kind   = KIND_SEGMENT_END;
            push_data.out_length = sub_inc;
            phase_next           = done_phase;
          end else if (ib == cfg.packet_end_marker) begin
            multi_total_next     = 16'd0;
            segment_number_next  = 8'd0;
            push_data.out_kind   = KIND_PACKET_END;
            push_data.out_length = total_sum;
            phase_next           = done_phase;
          end else begin
            push_data.out_byte   = ib;
            push_data.out_kind   = KIND_SEGMENT_DATA;
            push_data.out_length = sub_inc;
          end
        end
        default: ;
      endcase
    end

    if (!fire) begin
      push_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      header_count     <= 4'd0;
      payload_left     <= 16'd0;
      length_high_byte <= 8'd0;
      sub_count        <= 16'd0;
      multi_total      <= 16'd0;
      segment_number   <= 8'd0;
    end else if (fire) begin
      phase            <= phase_next;
      header_count     <= header_count_next;
      payload_left     <= payload_left_next;
      length_high_byte <= length_high_byte_next;
      sub_count        <= sub_count_next;
      multi_total      <= multi_total_next;
      segment_number   <= segment_number_next;
    end
  end

endmodule

// ===== rtl/tpd_out_buf.sv =====
module tpd_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  tpd_pkg::res_t push_data,
  output logic          buf_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tpd_pkg::res_t out_data
);
  import tpd_pkg::*;

  res_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign buf_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push_valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
